// File: rtl/npi_pkg.sv
// ----------------------------------------------------------------------------
// npi_pkg
// Shared types and constants of the nearest palette index core.
// ----------------------------------------------------------------------------
package npi_pkg;

  localparam int DEF_PALETTE_DEPTH = 256;
  localparam int MAX_SEARCH        = 256;

  localparam int COMP_W  = 8;
  localparam int IDX_W   = 8;
  localparam int SIZE_W  = 9;
  localparam int SQ_W    = 2 * COMP_W;
  localparam int SUM_W   = 18;   // three squared 8-bit differences
  localparam int ROOT_W  = 19;
  localparam int DIST_W  = 9;
  localparam int ENTRY_W = 3 * COMP_W;

  // highest power of four at or below the largest distance sum
  localparam logic [ROOT_W-1:0] ROOT_FIRST_BIT = ROOT_W'(1) << 16;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_MIN,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_THRESH,
    ST_SCAN_FIRST,
    ST_FINISH
  } npi_state_t;

endpackage

// File: rtl/nearest_palette_index_core.sv
// ----------------------------------------------------------------------------
// nearest_palette_index_core
// Palette store and nearest-color search by floored Euclidean RGB distance.
// ----------------------------------------------------------------------------
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   in       | in_valid / in_stall    | command, entry_index, red, green, blue,
//            |                        | last_pixel
//   out      | out_valid / out_stall  | color_index, distance, last_out
//   cfg      | cfg_we                 | cfg_data (palette_size)
//
// a write word is stored without leaving idle. a pixel word is searched in
// order: a first pass through the single palette read port finds the smallest
// squared distance, a shared one-bit-per-cycle root unit floors it in 9 steps,
// and a second pass finds the lowest index within that floor. input stalls
// while a pixel is searched.
// reset sets palette_size to 1; palette contents stay undefined until written.
// a finished result waits in the output register while new words are taken.
// ----------------------------------------------------------------------------
module nearest_palette_index_core
  import npi_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [COMP_W-1:0] red,
  input  logic [COMP_W-1:0] green,
  input  logic [COMP_W-1:0] blue,
  input  logic              last_pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  color_index,
  output logic [DIST_W-1:0] distance,
  output logic              last_out,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int AW        = $clog2(PALETTE_DEPTH);
  localparam int LIMIT_MAX = (PALETTE_DEPTH < MAX_SEARCH) ? PALETTE_DEPTH : MAX_SEARCH;

  npi_state_t state, state_next;

  logic [ENTRY_W-1:0] mem [PALETTE_DEPTH];

  logic [SIZE_W-1:0]  palette_size;
  logic [COMP_W-1:0]  px_r, px_g, px_b;
  logic               px_last;

  logic [SIZE_W-1:0]  iss;
  logic [SIZE_W-1:0]  scan_lim;
  logic               issue;
  logic               scan_done;
  logic               in_take;
  logic               out_load;

  // read pipeline
  logic               v1, v2;
  logic [IDX_W-1:0]   i1, i2;
  logic [ENTRY_W-1:0] rd_data;
  logic [SQ_W-1:0]    sq_r, sq_g, sq_b;
  logic [SUM_W-1:0]   sum;

  logic [SUM_W-1:0]   min_sq;
  logic [IDX_W-1:0]   arg_idx;
  logic [SUM_W-1:0]   thr;
  logic               found;
  logic [IDX_W-1:0]   hit_idx;

  // shared root unit
  logic [ROOT_W-1:0]  root_rem, root_res, root_bit;
  logic [ROOT_W-1:0]  root_trial;
  logic               root_take;

  logic [SIZE_W-1:0]  size_clamped;

  function automatic logic [SQ_W-1:0] diff_sq(input logic [COMP_W-1:0] a,
                                              input logic [COMP_W-1:0] b);
    logic [COMP_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  always_comb begin
    if (palette_size == '0) begin
      size_clamped = SIZE_W'(1);
    end else if (palette_size > SIZE_W'(LIMIT_MAX)) begin
      size_clamped = SIZE_W'(LIMIT_MAX);
    end else begin
      size_clamped = palette_size;
    end
  end

  assign sum        = SUM_W'(sq_r) + SUM_W'(sq_g) + SUM_W'(sq_b);
  assign root_trial = root_res + root_bit;
  assign root_take  = ROOT_W'(root_rem) >= root_trial;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take && command == CMD_PIXEL) begin
          state_next = ST_SCAN_MIN;
        end
      end
      ST_SCAN_MIN: begin
        if (scan_done) begin
          state_next = ST_ROOT_LOAD;
        end
      end
      ST_ROOT_LOAD: state_next = ST_ROOT;
      ST_ROOT: begin
        if (root_bit == ROOT_W'(1)) begin
          state_next = ST_THRESH;
        end
      end
      ST_THRESH: state_next = ST_SCAN_FIRST;
      ST_SCAN_FIRST: begin
        if (scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = (state != ST_IDLE);
    in_take   = in_valid && (state == ST_IDLE);
    issue     = (state == ST_SCAN_MIN || state == ST_SCAN_FIRST) && (iss < scan_lim);
    scan_done = (state == ST_SCAN_MIN || state == ST_SCAN_FIRST) &&
                (iss == scan_lim) && !v1;
    out_load  = (state == ST_FINISH) && (!out_valid || !out_stall);
  end

  // palette store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (in_take && command == CMD_WRITE &&
        32'(entry_index) < 32'(PALETTE_DEPTH)) begin
      mem[AW'(entry_index)] <= {red, green, blue};
    end
    if (issue) begin
      rd_data <= mem[AW'(iss[IDX_W-1:0])];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      palette_size <= SIZE_W'(1);
      v1           <= 1'b0;
      v2           <= 1'b0;
      out_valid    <= 1'b0;
      found        <= 1'b0;
      iss          <= '0;
      scan_lim     <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        palette_size <= cfg_data;
      end
      v1 <= issue;
      v2 <= v1;
      if (issue) begin
        iss <= iss + SIZE_W'(1);
      end
      if (in_take && command == CMD_PIXEL) begin
        iss      <= '0;
        scan_lim <= size_clamped;
      end
      if (state == ST_THRESH) begin
        iss      <= '0;
        scan_lim <= SIZE_W'(arg_idx) + SIZE_W'(1);
        found    <= 1'b0;
      end
      if (state == ST_SCAN_FIRST && v2 && !found && sum <= thr) begin
        found <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      px_r    <= red;
      px_g    <= green;
      px_b    <= blue;
      px_last <= last_pixel;
      min_sq  <= '1;
    end
    i1   <= iss[IDX_W-1:0];
    i2   <= i1;
    sq_r <= diff_sq(px_r, rd_data[3*COMP_W-1:2*COMP_W]);
    sq_g <= diff_sq(px_g, rd_data[2*COMP_W-1:COMP_W]);
    sq_b <= diff_sq(px_b, rd_data[COMP_W-1:0]);

    // strict compare keeps the lowest index of the smallest sum
    if (state == ST_SCAN_MIN && v2 && sum < min_sq) begin
      min_sq  <= sum;
      arg_idx <= i2;
    end

    case (state)
      ST_ROOT_LOAD: begin
        root_rem <= ROOT_W'(min_sq);
        root_res <= '0;
        root_bit <= ROOT_FIRST_BIT;
      end
      ST_ROOT: begin
        if (root_take) begin
          root_rem <= root_rem - root_trial;
          root_res <= (root_res >> 1) + root_bit;
        end else begin
          root_res <= root_res >> 1;
        end
        root_bit <= root_bit >> 2;
      end
      default: begin
      end
    endcase

    // largest sum with the same floored root: (f+1)^2 - 1
    if (state == ST_THRESH) begin
      thr <= (min_sq - root_rem[SUM_W-1:0]) + SUM_W'({root_res[DIST_W-1:0], 1'b0});
    end

    if (state == ST_SCAN_FIRST && v2 && !found && sum <= thr) begin
      hit_idx <= i2;
    end

    if (out_load) begin
      color_index <= hit_idx;
      distance    <= root_res[DIST_W-1:0];
      last_out    <= px_last;
    end
  end

  // a result word only comes out of the finish step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result word without a finished search");

  // the second pass always meets the entry found by the first
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> found)
    else $error("second pass found no entry within the floored distance");

  // the smallest sum lies within its own floor band
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_FIRST) |-> (min_sq <= thr))
    else $error("threshold below smallest distance sum");

  // the read counter never runs past the pass limit
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_MIN || state == ST_SCAN_FIRST) |-> (iss <= scan_lim))
    else $error("palette read past the search limit");

endmodule
